/* hdl/spfp_pkg.sv */
// shared constants and the crc-8 fold for the sample pair frame packer
package spfp_pkg;

    localparam logic [7:0] SYNC_BYTE      = 8'hFA;
    localparam logic [7:0] CRC_POLY       = 8'h07;
    localparam int         BYTES_PER_PAIR = 6;
    localparam int         BYTE_CNT_W     = 3;
    localparam int         CODE_W         = 24;

    typedef logic [7:0] byte_t;

    // one byte through crc-8 (poly 0x07, msb first)
    function automatic byte_t crc_fold(input byte_t crc, input byte_t data);
        byte_t c;
        c = crc ^ data;
        for (int b = 0; b < 8; b++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

/* hdl/spfp_ram.sv */
// generic single-port-write, single-port-read ram with registered read data
module spfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 30
) (
    input  logic                                 aclk,
    input  logic                                 wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                     wr_data,
    input  logic                                 rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                     rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        // read data holds while no read is issued
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hdl/sample_pair_frame_packer_crc8.sv */
// sample pair frame packer: payload ram, crc-8/smbus and byte-serial frame output
//
//  channel | ports                                   | direction | role
//  s_      | first/second_channel_code, sink_ready   | in        | one sample pair
//  m_      | frame_byte/last/dropped, dropped_total  | out       | frame bytes or drop
//
// a pair is taken in idle, then its six bytes are written through the single
// write port of the payload ram, crc folded one byte per cycle alongside.
// a completed frame then streams 3 + 6*SAMPLES_PER_FRAME bytes, one per cycle while
// m_ready is high, the ram read issued one byte ahead; a dropped frame gives one result.
// reset is synchronous and clears control state; the payload ram is not cleared.
// m_ready low holds a waiting result and the emission; s_ready is high only when idle.
module sample_pair_frame_packer_crc8 #(
    parameter int SAMPLES_PER_FRAME = 5
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [23:0] s_first_channel_code,
    input  logic [23:0] s_second_channel_code,
    input  logic        s_sink_ready,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_frame_byte,
    output logic        m_frame_last,
    output logic        m_frame_dropped,
    output logic [31:0] m_dropped_total
);

    localparam int PAYLOAD_BYTES = spfp_pkg::BYTES_PER_PAIR * SAMPLES_PER_FRAME;
    localparam int ADDR_W        = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
    localparam int PAIR_W        = (SAMPLES_PER_FRAME > 1) ? $clog2(SAMPLES_PER_FRAME) : 1;
    localparam int FRAME_BYTES   = PAYLOAD_BYTES + 3;
    localparam int IDX_W         = $clog2(FRAME_BYTES);
    localparam int CNT_W         = spfp_pkg::BYTE_CNT_W;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_WRITE = 2'd1;
    localparam logic [1:0] S_EMIT  = 2'd2;
    localparam logic [1:0] S_DROP  = 2'd3;

    localparam logic [CNT_W-1:0]  CNT_LAST  = CNT_W'(spfp_pkg::BYTES_PER_PAIR - 1);
    localparam logic [PAIR_W-1:0] PAIR_LAST = PAIR_W'(SAMPLES_PER_FRAME - 1);
    localparam logic [IDX_W-1:0]  IDX_SEQ   = IDX_W'(1);
    localparam logic [IDX_W-1:0]  IDX_PL_HI = IDX_W'(PAYLOAD_BYTES);
    localparam logic [IDX_W-1:0]  IDX_CRC   = IDX_W'(FRAME_BYTES - 1);

    logic [1:0]                  state_reg;
    logic [47:0]                 pair_data_reg;
    logic                        sink_ready_reg;
    logic [CNT_W-1:0]            byte_cnt_reg;
    logic [ADDR_W-1:0]           wr_addr_reg;
    logic [PAIR_W-1:0]           pair_index_reg;
    logic [7:0]                  sequence_reg;
    spfp_pkg::byte_t             crc_reg;
    logic [31:0]                 dropped_reg;
    logic [IDX_W-1:0]            emit_idx_reg;

    logic                        m_valid_reg;
    logic [7:0]                  m_byte_reg;
    logic                        m_last_reg;
    logic                        m_dropped_reg;
    logic [31:0]                 m_total_reg;

    logic                        s_take;
    logic                        out_free;
    logic                        m_load;
    spfp_pkg::byte_t             wr_byte;
    logic                        ram_we;
    logic                        ram_re;
    logic [ADDR_W-1:0]           ram_raddr;
    spfp_pkg::byte_t             ram_rdata;
    spfp_pkg::byte_t             emit_byte;
    logic [31:0]                 dropped_sum;

    assign s_ready  = (state_reg == S_IDLE);
    assign s_take   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_load   = out_free && ((state_reg == S_EMIT) || (state_reg == S_DROP));

    always_comb begin
        case (byte_cnt_reg)
            3'd0:    wr_byte = pair_data_reg[47:40];
            3'd1:    wr_byte = pair_data_reg[39:32];
            3'd2:    wr_byte = pair_data_reg[31:24];
            3'd3:    wr_byte = pair_data_reg[23:16];
            3'd4:    wr_byte = pair_data_reg[15:8];
            default: wr_byte = pair_data_reg[7:0];
        endcase
    end

    assign ram_we = (state_reg == S_WRITE);

    // read of payload byte k-1 goes out as byte k loads, ready for the next load
    assign ram_re    = (state_reg == S_EMIT) && out_free &&
                       (emit_idx_reg >= IDX_SEQ) && (emit_idx_reg <= IDX_PL_HI);
    assign ram_raddr = ADDR_W'(emit_idx_reg - IDX_SEQ);

    always_comb begin
        if (emit_idx_reg == '0) begin
            emit_byte = spfp_pkg::SYNC_BYTE;
        end else if (emit_idx_reg == IDX_SEQ) begin
            emit_byte = sequence_reg;
        end else if (emit_idx_reg == IDX_CRC) begin
            emit_byte = crc_reg;
        end else begin
            emit_byte = ram_rdata;
        end
    end

    assign dropped_sum = dropped_reg + 32'(SAMPLES_PER_FRAME);

    spfp_ram #(
        .WIDTH (8),
        .DEPTH (PAYLOAD_BYTES)
    ) u_payload_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (wr_addr_reg),
        .wr_data (wr_byte),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            byte_cnt_reg   <= '0;
            wr_addr_reg    <= '0;
            pair_index_reg <= '0;
            sequence_reg   <= '0;
            crc_reg        <= '0;
            dropped_reg    <= '0;
            emit_idx_reg   <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (m_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_take) begin
                        pair_data_reg  <= {s_first_channel_code, s_second_channel_code};
                        sink_ready_reg <= s_sink_ready;
                        byte_cnt_reg   <= '0;
                        if (pair_index_reg == '0) begin
                            crc_reg <= spfp_pkg::crc_fold(8'h00, sequence_reg);
                        end
                        state_reg <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    crc_reg      <= spfp_pkg::crc_fold(crc_reg, wr_byte);
                    byte_cnt_reg <= byte_cnt_reg + 1'b1;
                    if (byte_cnt_reg == CNT_LAST) begin
                        if (pair_index_reg == PAIR_LAST) begin
                            pair_index_reg <= '0;
                            wr_addr_reg    <= '0;
                            emit_idx_reg   <= '0;
                            state_reg      <= sink_ready_reg ? S_EMIT : S_DROP;
                        end else begin
                            pair_index_reg <= pair_index_reg + 1'b1;
                            wr_addr_reg    <= wr_addr_reg + 1'b1;
                            state_reg      <= S_IDLE;
                        end
                    end else begin
                        wr_addr_reg <= wr_addr_reg + 1'b1;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        m_byte_reg    <= emit_byte;
                        m_last_reg    <= (emit_idx_reg == IDX_CRC);
                        m_dropped_reg <= 1'b0;
                        m_total_reg   <= dropped_reg;
                        emit_idx_reg  <= emit_idx_reg + 1'b1;
                        if (emit_idx_reg == IDX_CRC) begin
                            sequence_reg <= sequence_reg + 1'b1;
                            state_reg    <= S_IDLE;
                        end
                    end
                end
                S_DROP: begin
                    if (out_free) begin
                        m_byte_reg    <= 8'h00;
                        m_last_reg    <= 1'b0;
                        m_dropped_reg <= 1'b1;
                        m_total_reg   <= dropped_sum;
                        dropped_reg   <= dropped_sum;
                        sequence_reg  <= sequence_reg + 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_frame_byte    = m_byte_reg;
    assign m_frame_last    = m_last_reg;
    assign m_frame_dropped = m_dropped_reg;
    assign m_dropped_total = m_total_reg;

`ifndef ASSERT_OFF
    // payload reads and writes never share a cycle
    a_no_rw_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ram_we && ram_re))
        else $error("payload ram read and write in the same cycle");

    // a waiting result holds still until it is taken
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=>
        (m_valid && $stable(m_frame_byte) && $stable(m_frame_last) &&
         $stable(m_frame_dropped) && $stable(m_dropped_total)))
        else $error("result changed while waiting");

    // a drop raises the count by one frame of samples
    a_drop_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DROP && out_free) |=>
        (dropped_reg == $past(dropped_reg) + 32'(SAMPLES_PER_FRAME)))
        else $error("drop count not advanced by one frame");

    // sequence advances exactly when a frame closes
    a_seq_step: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == S_DROP || (state_reg == S_EMIT && emit_idx_reg == IDX_CRC))
         && out_free) |=> (sequence_reg == $past(sequence_reg) + 8'd1))
        else $error("sequence number did not advance at frame end");

    // the last byte of a frame is never a drop result
    a_last_not_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_frame_last && m_frame_dropped))
        else $error("frame_last and frame_dropped both set");
`endif

endmodule
